// ----- hw/rtl/hcb_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Huffman code builder package
// Shared opcodes, status codes and the sequencer state type.
// ----------------------------------------------------------------------------
package hcb_pkg;

   localparam logic [2:0] FUNC_APPEND = 3'd0;
   localparam logic [2:0] FUNC_BUILD  = 3'd1;
   localparam logic [2:0] FUNC_CODE   = 3'd2;
   localparam logic [2:0] FUNC_RANK   = 3'd3;
   localparam logic [2:0] FUNC_CLEAR  = 3'd4;

   localparam logic [1:0] STAT_OK       = 2'd0;
   localparam logic [1:0] STAT_ABSENT   = 2'd1;
   localparam logic [1:0] STAT_TOO_LONG = 2'd2;
   localparam logic [1:0] STAT_NO_CODE  = 2'd3;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_APPEND,
      ST_QCODE,
      ST_RSCAN,
      ST_ROUT,
      ST_LD_ARR,
      ST_LD_CNT,
      ST_LD_PUT,
      ST_SORT_RD,
      ST_SORT_GET,
      ST_SORT_CMP,
      ST_SORT_PUT,
      ST_MRG_A,
      ST_MRG_B,
      ST_MRG_MAKE,
      ST_CODE_ROOT,
      ST_CODE_RD,
      ST_CODE_L,
      ST_CODE_R,
      ST_TBL_RD,
      ST_TBL_WR,
      ST_RESP
   } state_type;

endpackage

// ----- hw/rtl/hcb_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Huffman code builder RAM
// Simple dual-port RAM with one write port and a registered read port.
// ----------------------------------------------------------------------------
module hcb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/huffman_code_builder_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Huffman code builder core
// Counts byte symbols, builds a Huffman code for them and answers queries.
// ----------------------------------------------------------------------------
// The request channel carries one command per beat: the opcode in req_tuser
// and the symbol and rank in req_tdata. Every command gives exactly one
// response beat with a status in rsp_tuser and the entry in rsp_tdata.
// An append or a code query makes one read of the count or code table RAM
// before its result reaches the response register. A rank query scans the
// present-symbol flags one symbol per cycle. A build walks the tables in
// RAM: it loads the n leaves, runs the insertion sort and each merge
// insertion as a series of compares, walks the tree node by node for the
// codes and then fills the code table, where n is the number of distinct
// symbols. One command is in work at a time. A finished response waits in
// the output register while the next command is accepted; the block holds
// its next response until the receiver takes the last one. Reset empties
// the string and the counts at once and clears the code.
// ----------------------------------------------------------------------------
module huffman_code_builder_core #(
   parameter int MAX_LENGTH    = 1024,
   parameter int ALPHABET_SIZE = 256,
   parameter int CODE_WIDTH    = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,  // symbol[7:0], rank[15:8]
   input  logic [2:0]  req_tuser,  // func[2:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,  // out_symbol[7:0], code_bits[39:8],
                                   // code_length[45:40], distinct_count[54:46]
   output logic [1:0]  rsp_tuser   // status[1:0]
);

   localparam int AW    = $clog2(ALPHABET_SIZE);
   localparam int ND    = 2 * ALPHABET_SIZE - 1;
   localparam int NW    = $clog2(ND);
   localparam int DW    = $clog2(ALPHABET_SIZE + 1);
   localparam int LW    = $clog2(MAX_LENGTH + 1);
   localparam int CLW   = $clog2(CODE_WIDTH + 1);
   localparam int CODEW = CLW + CODE_WIDTH;
   localparam int NODEW = LW + 2 * NW;
   localparam int WLW   = LW + NW;

   hcb_pkg::state_type state_ff, state_in;

   logic [2:0]             func_ff, func_in;
   logic [7:0]             sym_ff, sym_in;
   logic [7:0]             rank_ff, rank_in;
   logic [ALPHABET_SIZE-1:0] vld_ff, vld_in;
   logic [DW-1:0]          distinct_ff, distinct_in;
   logic [LW-1:0]          loaded_ff, loaded_in;
   logic                   built_ff, built_in;
   logic [NW-1:0]          idx_ff, idx_in;
   logic [NW-1:0]          k_ff, k_in;
   logic [NW-1:0]          len_ff, len_in;
   logic [NW-1:0]          next_ff, next_in;
   logic                   merge_ff, merge_in;
   logic [WLW-1:0]         v_ff, v_in;
   logic [WLW-1:0]         a_ff, a_in;
   logic [AW-1:0]          scan_ff, scan_in;
   logic [DW-1:0]          rnk_ff, rnk_in;
   logic [NW-1:0]          right_ff, right_in;
   logic [CODEW-1:0]       pc_ff, pc_in;
   logic [1:0]             res_status_ff, res_status_in;
   logic [7:0]             res_sym_ff, res_sym_in;
   logic [CODEW-1:0]       res_code_ff, res_code_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [55:0]            rsp_data_ff, rsp_data_in;
   logic [1:0]             rsp_user_ff, rsp_user_in;

   logic                   cnt_we;
   logic [AW-1:0]          cnt_wa, cnt_ra;
   logic [LW-1:0]          cnt_wd, cnt_rd;
   logic                   arr_we;
   logic [AW-1:0]          arr_wa, arr_ra;
   logic [7:0]             arr_wd, arr_rd;
   logic                   node_we;
   logic [NW-1:0]          node_wa, node_ra;
   logic [NODEW-1:0]       node_wd, node_rd;
   logic                   wl_we;
   logic [AW-1:0]          wl_wa, wl_ra;
   logic [WLW-1:0]         wl_wd, wl_rd;
   logic                   nc_we;
   logic [NW-1:0]          nc_wa, nc_ra;
   logic [CODEW-1:0]       nc_wd, nc_rd;
   logic                   ct_we;
   logic [AW-1:0]          ct_wa, ct_ra;
   logic [CODEW-1:0]       ct_wd, ct_rd;

   logic                   req_accept;
   logic [2:0]             req_func;
   logic [7:0]             req_sym;
   logic [7:0]             req_rank;
   logic [NW-1:0]          n_ext;
   logic                   sym_bad;
   logic [LW-1:0]          cnt_old;
   logic [LW-1:0]          merged_w;
   logic [63:0]            bits_ext;

   function automatic logic [CODEW-1:0] extend_code(input logic [CODEW-1:0] code,
                                                    input logic bit_val);
      logic [CLW-1:0]        clen;
      logic [CODE_WIDTH-1:0] cbits;
      clen  = code[CODEW-1:CODE_WIDTH];
      cbits = code[CODE_WIDTH-1:0];
      if (clen < CLW'(CODE_WIDTH)) begin
         extend_code = {clen + CLW'(1), cbits[CODE_WIDTH-2:0], bit_val};
      end else begin
         extend_code = code;
      end
   endfunction

   assign req_func   = req_tuser;
   assign req_sym    = req_tdata[7:0];
   assign req_rank   = req_tdata[15:8];
   assign req_tready = (state_ff == hcb_pkg::ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign n_ext      = NW'(distinct_ff);
   assign sym_bad    = ({1'b0, sym_ff} >= 9'(ALPHABET_SIZE));
   assign cnt_old    = vld_ff[sym_ff[AW-1:0]] ? cnt_rd : '0;
   assign merged_w   = a_ff[WLW-1:NW] + wl_rd[WLW-1:NW];

   hcb_ram #(.WIDTH(LW), .DEPTH(ALPHABET_SIZE)) u_cnt_ram (
      .clock(clock), .wr_en(cnt_we), .wr_addr(cnt_wa), .wr_data(cnt_wd),
      .rd_addr(cnt_ra), .rd_data(cnt_rd)
   );

   hcb_ram #(.WIDTH(8), .DEPTH(ALPHABET_SIZE)) u_arr_ram (
      .clock(clock), .wr_en(arr_we), .wr_addr(arr_wa), .wr_data(arr_wd),
      .rd_addr(arr_ra), .rd_data(arr_rd)
   );

   hcb_ram #(.WIDTH(NODEW), .DEPTH(ND)) u_node_ram (
      .clock(clock), .wr_en(node_we), .wr_addr(node_wa), .wr_data(node_wd),
      .rd_addr(node_ra), .rd_data(node_rd)
   );

   hcb_ram #(.WIDTH(WLW), .DEPTH(ALPHABET_SIZE)) u_wl_ram (
      .clock(clock), .wr_en(wl_we), .wr_addr(wl_wa), .wr_data(wl_wd),
      .rd_addr(wl_ra), .rd_data(wl_rd)
   );

   hcb_ram #(.WIDTH(CODEW), .DEPTH(ND)) u_nc_ram (
      .clock(clock), .wr_en(nc_we), .wr_addr(nc_wa), .wr_data(nc_wd),
      .rd_addr(nc_ra), .rd_data(nc_rd)
   );

   hcb_ram #(.WIDTH(CODEW), .DEPTH(ALPHABET_SIZE)) u_ct_ram (
      .clock(clock), .wr_en(ct_we), .wr_addr(ct_wa), .wr_data(ct_wd),
      .rd_addr(ct_ra), .rd_data(ct_rd)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         hcb_pkg::ST_IDLE: begin
            if (req_accept) begin
               unique case (req_func)
                  hcb_pkg::FUNC_APPEND: state_in = hcb_pkg::ST_APPEND;
                  hcb_pkg::FUNC_BUILD: begin
                     state_in = (distinct_ff == '0) ? hcb_pkg::ST_RESP : hcb_pkg::ST_LD_ARR;
                  end
                  hcb_pkg::FUNC_CODE: state_in = hcb_pkg::ST_QCODE;
                  hcb_pkg::FUNC_RANK: begin
                     if (!built_ff || ({1'b0, req_rank} >= 9'(distinct_ff))) begin
                        state_in = hcb_pkg::ST_RESP;
                     end else begin
                        state_in = hcb_pkg::ST_RSCAN;
                     end
                  end
                  default: state_in = hcb_pkg::ST_RESP;
               endcase
            end
         end
         hcb_pkg::ST_APPEND: state_in = hcb_pkg::ST_RESP;
         hcb_pkg::ST_QCODE: state_in = hcb_pkg::ST_RESP;
         hcb_pkg::ST_RSCAN: begin
            if (vld_ff[scan_ff] && (9'(rnk_ff) == {1'b0, rank_ff})) begin
               state_in = hcb_pkg::ST_ROUT;
            end
         end
         hcb_pkg::ST_ROUT: state_in = hcb_pkg::ST_RESP;
         hcb_pkg::ST_LD_ARR: state_in = hcb_pkg::ST_LD_CNT;
         hcb_pkg::ST_LD_CNT: state_in = hcb_pkg::ST_LD_PUT;
         hcb_pkg::ST_LD_PUT: begin
            state_in = (idx_ff + NW'(1) == n_ext) ? hcb_pkg::ST_SORT_RD : hcb_pkg::ST_LD_ARR;
         end
         hcb_pkg::ST_SORT_RD: begin
            state_in = (idx_ff == n_ext) ? hcb_pkg::ST_MRG_A : hcb_pkg::ST_SORT_GET;
         end
         hcb_pkg::ST_SORT_GET: state_in = hcb_pkg::ST_SORT_CMP;
         hcb_pkg::ST_SORT_CMP: begin
            if (wl_rd[WLW-1:NW] < v_ff[WLW-1:NW]) begin
               if (k_ff == NW'(1)) begin
                  state_in = hcb_pkg::ST_SORT_PUT;
               end
            end else begin
               state_in = merge_ff ? hcb_pkg::ST_MRG_A : hcb_pkg::ST_SORT_RD;
            end
         end
         hcb_pkg::ST_SORT_PUT: begin
            state_in = merge_ff ? hcb_pkg::ST_MRG_A : hcb_pkg::ST_SORT_RD;
         end
         hcb_pkg::ST_MRG_A: begin
            state_in = (len_ff > NW'(1)) ? hcb_pkg::ST_MRG_B : hcb_pkg::ST_CODE_ROOT;
         end
         hcb_pkg::ST_MRG_B: state_in = hcb_pkg::ST_MRG_MAKE;
         hcb_pkg::ST_MRG_MAKE: begin
            state_in = (len_ff == NW'(2)) ? hcb_pkg::ST_SORT_PUT : hcb_pkg::ST_SORT_CMP;
         end
         hcb_pkg::ST_CODE_ROOT: begin
            state_in = (next_ff > n_ext) ? hcb_pkg::ST_CODE_RD : hcb_pkg::ST_TBL_RD;
         end
         hcb_pkg::ST_CODE_RD: state_in = hcb_pkg::ST_CODE_L;
         hcb_pkg::ST_CODE_L: state_in = hcb_pkg::ST_CODE_R;
         hcb_pkg::ST_CODE_R: begin
            state_in = (k_ff == n_ext) ? hcb_pkg::ST_TBL_RD : hcb_pkg::ST_CODE_RD;
         end
         hcb_pkg::ST_TBL_RD: state_in = hcb_pkg::ST_TBL_WR;
         hcb_pkg::ST_TBL_WR: begin
            state_in = (idx_ff + NW'(1) == n_ext) ? hcb_pkg::ST_RESP : hcb_pkg::ST_TBL_RD;
         end
         hcb_pkg::ST_RESP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               state_in = hcb_pkg::ST_IDLE;
            end
         end
         default: state_in = hcb_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      func_in       = func_ff;
      sym_in        = sym_ff;
      rank_in       = rank_ff;
      vld_in        = vld_ff;
      distinct_in   = distinct_ff;
      loaded_in     = loaded_ff;
      built_in      = built_ff;
      idx_in        = idx_ff;
      k_in          = k_ff;
      len_in        = len_ff;
      next_in       = next_ff;
      merge_in      = merge_ff;
      v_in          = v_ff;
      a_in          = a_ff;
      scan_in       = scan_ff;
      rnk_in        = rnk_ff;
      right_in      = right_ff;
      pc_in         = pc_ff;
      res_status_in = res_status_ff;
      res_sym_in    = res_sym_ff;
      res_code_in   = res_code_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      rsp_user_in   = rsp_user_ff;
      bits_ext      = 64'(res_code_ff[CODE_WIDTH-1:0]);

      cnt_we  = 1'b0;
      cnt_wa  = sym_ff[AW-1:0];
      cnt_wd  = cnt_old + LW'(1);
      cnt_ra  = req_sym[AW-1:0];
      arr_we  = 1'b0;
      arr_wa  = distinct_ff[AW-1:0];
      arr_wd  = sym_ff;
      arr_ra  = idx_ff[AW-1:0];
      node_we = 1'b0;
      node_wa = idx_ff;
      node_wd = {cnt_rd, {(2 * NW){1'b0}}};
      node_ra = k_ff;
      wl_we   = 1'b0;
      wl_wa   = k_ff[AW-1:0];
      wl_wd   = wl_rd;
      wl_ra   = k_ff[AW-1:0] - AW'(2);
      nc_we   = 1'b0;
      nc_wa   = node_rd[2*NW-1:NW];
      nc_wd   = extend_code(nc_rd, 1'b0);
      nc_ra   = k_ff;
      ct_we   = 1'b0;
      ct_wa   = arr_rd[AW-1:0];
      ct_wd   = nc_rd;
      ct_ra   = req_sym[AW-1:0];

      unique case (state_ff)
         hcb_pkg::ST_IDLE: begin
            if (req_accept) begin
               func_in       = req_func;
               sym_in        = req_sym;
               rank_in       = req_rank;
               res_status_in = hcb_pkg::STAT_OK;
               res_sym_in    = '0;
               res_code_in   = '0;
               idx_in        = '0;
               scan_in       = '0;
               rnk_in        = '0;
               merge_in      = 1'b0;
               unique case (req_func)
                  hcb_pkg::FUNC_APPEND, hcb_pkg::FUNC_CODE: begin
                  end
                  hcb_pkg::FUNC_BUILD: begin
                     if (distinct_ff == '0) begin
                        res_status_in = hcb_pkg::STAT_ABSENT;
                     end
                  end
                  hcb_pkg::FUNC_RANK: begin
                     if (!built_ff) begin
                        res_status_in = hcb_pkg::STAT_NO_CODE;
                     end else if ({1'b0, req_rank} >= 9'(distinct_ff)) begin
                        res_status_in = hcb_pkg::STAT_ABSENT;
                     end
                  end
                  hcb_pkg::FUNC_CLEAR: begin
                     vld_in      = '0;
                     distinct_in = '0;
                     loaded_in   = '0;
                     built_in    = 1'b0;
                  end
                  default: res_status_in = hcb_pkg::STAT_ABSENT;
               endcase
            end
         end
         hcb_pkg::ST_APPEND: begin
            if (sym_bad) begin
               res_status_in = hcb_pkg::STAT_ABSENT;
            end else if (loaded_ff >= LW'(MAX_LENGTH)) begin
               res_status_in = hcb_pkg::STAT_TOO_LONG;
            end else begin
               cnt_we = 1'b1;
               vld_in[sym_ff[AW-1:0]] = 1'b1;
               if (!vld_ff[sym_ff[AW-1:0]] && (distinct_ff < DW'(ALPHABET_SIZE))) begin
                  arr_we      = 1'b1;
                  distinct_in = distinct_ff + DW'(1);
               end
               loaded_in = loaded_ff + LW'(1);
               built_in  = 1'b0;
            end
         end
         hcb_pkg::ST_QCODE: begin
            if (!built_ff) begin
               res_status_in = hcb_pkg::STAT_NO_CODE;
            end else if (sym_bad || !vld_ff[sym_ff[AW-1:0]]) begin
               res_status_in = hcb_pkg::STAT_ABSENT;
            end else begin
               res_sym_in  = sym_ff;
               res_code_in = ct_rd;
            end
         end
         hcb_pkg::ST_RSCAN: begin
            ct_ra = scan_ff;
            if (vld_ff[scan_ff]) begin
               if (9'(rnk_ff) != {1'b0, rank_ff}) begin
                  rnk_in  = rnk_ff + DW'(1);
                  scan_in = scan_ff + AW'(1);
               end
            end else begin
               scan_in = scan_ff + AW'(1);
            end
         end
         hcb_pkg::ST_ROUT: begin
            res_sym_in  = 8'(scan_ff);
            res_code_in = ct_rd;
         end
         hcb_pkg::ST_LD_ARR: begin
            arr_ra = idx_ff[AW-1:0];
         end
         hcb_pkg::ST_LD_CNT: begin
            cnt_ra = arr_rd[AW-1:0];
         end
         hcb_pkg::ST_LD_PUT: begin
            node_we = 1'b1;
            wl_we   = 1'b1;
            wl_wa   = idx_ff[AW-1:0];
            wl_wd   = {cnt_rd, idx_ff};
            if (idx_ff + NW'(1) == n_ext) begin
               idx_in = NW'(1);
            end else begin
               idx_in = idx_ff + NW'(1);
            end
         end
         hcb_pkg::ST_SORT_RD: begin
            wl_ra = idx_ff[AW-1:0];
            if (idx_ff == n_ext) begin
               len_in   = n_ext;
               next_in  = n_ext;
               merge_in = 1'b1;
            end
         end
         hcb_pkg::ST_SORT_GET: begin
            v_in  = wl_rd;
            k_in  = idx_ff;
            wl_ra = idx_ff[AW-1:0] - AW'(1);
         end
         hcb_pkg::ST_SORT_CMP: begin
            wl_we = 1'b1;
            if (wl_rd[WLW-1:NW] < v_ff[WLW-1:NW]) begin
               wl_wd = wl_rd;
               k_in  = k_ff - NW'(1);
            end else begin
               wl_wd = v_ff;
               if (merge_ff) begin
                  len_in  = len_ff + NW'(1);
                  next_in = next_ff + NW'(1);
               end else begin
                  idx_in = idx_ff + NW'(1);
               end
            end
         end
         hcb_pkg::ST_SORT_PUT: begin
            wl_we = 1'b1;
            wl_wa = '0;
            wl_wd = v_ff;
            if (merge_ff) begin
               len_in  = len_ff + NW'(1);
               next_in = next_ff + NW'(1);
            end else begin
               idx_in = idx_ff + NW'(1);
            end
         end
         hcb_pkg::ST_MRG_A: begin
            wl_ra = len_ff[AW-1:0] - AW'(1);
            k_in  = next_ff - NW'(1);
         end
         hcb_pkg::ST_MRG_B: begin
            a_in  = wl_rd;
            wl_ra = len_ff[AW-1:0] - AW'(2);
         end
         hcb_pkg::ST_MRG_MAKE: begin
            node_we = 1'b1;
            node_wa = next_ff;
            node_wd = {merged_w, a_ff[NW-1:0], wl_rd[NW-1:0]};
            v_in    = {merged_w, next_ff};
            len_in  = len_ff - NW'(2);
            k_in    = len_ff - NW'(2);
            wl_ra   = len_ff[AW-1:0] - AW'(3);
         end
         hcb_pkg::ST_CODE_ROOT: begin
            nc_we  = 1'b1;
            nc_wa  = k_ff;
            nc_wd  = '0;
            idx_in = '0;
         end
         hcb_pkg::ST_CODE_RD: begin
            node_ra = k_ff;
            nc_ra   = k_ff;
         end
         hcb_pkg::ST_CODE_L: begin
            nc_we    = 1'b1;
            right_in = node_rd[NW-1:0];
            pc_in    = nc_rd;
         end
         hcb_pkg::ST_CODE_R: begin
            nc_we = 1'b1;
            nc_wa = right_ff;
            nc_wd = extend_code(pc_ff, 1'b1);
            k_in  = k_ff - NW'(1);
         end
         hcb_pkg::ST_TBL_RD: begin
            arr_ra = idx_ff[AW-1:0];
            nc_ra  = idx_ff;
         end
         hcb_pkg::ST_TBL_WR: begin
            ct_we  = 1'b1;
            idx_in = idx_ff + NW'(1);
            if (idx_ff + NW'(1) == n_ext) begin
               built_in = 1'b1;
            end
         end
         hcb_pkg::ST_RESP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_user_in  = res_status_ff;
               rsp_data_in  = {1'b0, 9'(distinct_ff), 6'(res_code_ff[CODEW-1:CODE_WIDTH]),
                               bits_ext[31:0], res_sym_ff};
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= hcb_pkg::ST_IDLE;
         vld_ff       <= '0;
         distinct_ff  <= '0;
         loaded_ff    <= '0;
         built_ff     <= 1'b0;
         merge_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         vld_ff       <= vld_in;
         distinct_ff  <= distinct_in;
         loaded_ff    <= loaded_in;
         built_ff     <= built_in;
         merge_ff     <= merge_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff       <= func_in;
      sym_ff        <= sym_in;
      rank_ff       <= rank_in;
      idx_ff        <= idx_in;
      k_ff          <= k_in;
      len_ff        <= len_in;
      next_ff       <= next_in;
      v_ff          <= v_in;
      a_ff          <= a_in;
      scan_ff       <= scan_in;
      rnk_ff        <= rnk_in;
      right_ff      <= right_in;
      pc_ff         <= pc_in;
      res_status_ff <= res_status_in;
      res_sym_ff    <= res_sym_in;
      res_code_ff   <= res_code_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_user_ff   <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

`ifndef NO_ASSERTIONS
   a_distinct_bound : assert property (@(posedge clock) disable iff (reset)
      distinct_ff <= DW'(ALPHABET_SIZE))
      else $error("distinct symbol count exceeds the alphabet");

   a_clear_empties : assert property (@(posedge clock) disable iff (reset)
      (req_accept && (req_func == hcb_pkg::FUNC_CLEAR)) |=>
      ((distinct_ff == '0) && (loaded_ff == '0) && !built_ff))
      else $error("clear did not empty the string");

   a_built_source : assert property (@(posedge clock) disable iff (reset)
      $rose(built_ff) |-> $past(state_ff == hcb_pkg::ST_TBL_WR))
      else $error("code marked built outside the table pass");

   a_sort_index : assert property (@(posedge clock) disable iff (reset)
      (state_ff == hcb_pkg::ST_SORT_CMP) |-> (k_ff != '0))
      else $error("insertion compare at list head");

   a_func_held : assert property (@(posedge clock) disable iff (reset)
      (state_ff != hcb_pkg::ST_IDLE) && !$past(req_accept) |-> $stable(func_ff))
      else $error("command changed while in work");
`endif

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Huffman code builder testbench
// Drives append, build, query and clear commands into the core and checks
// every response beat against a model of the code builder kept in the bench.
// Short strings with repeated symbols make up most of the traffic, and one
// long string fills the whole alphabet and runs past the length limit.
// ----------------------------------------------------------------------------
module tb;
   import hcb_pkg::*;

   localparam int MAX_LEN  = 1024;
   localparam int ALPHABET = 256;
   localparam int CODE_W   = 32;
   localparam int NODES    = 2 * ALPHABET - 1;
   localparam int ITEMS    = 950;

   typedef struct {
      logic [1:0]  status;
      logic [7:0]  symbol;
      logic [31:0] bits;
      logic [5:0]  length;
      logic [8:0]  distinct;
   } answer_t;

   class code_scoreboard;
      int          counts[ALPHABET];
      logic [7:0]  arrival[ALPHABET];
      int          distinct;
      int          str_len;
      bit          built;
      logic [31:0] tbl_bits[ALPHABET];
      int          tbl_len[ALPHABET];
      answer_t     answers[$];
      int          errors;

      function void build_tree();
         int          wt[NODES];
         int          lft[NODES];
         int          rgt[NODES];
         logic [31:0] nb[NODES];
         int          nl[NODES];
         int          wl[ALPHABET + 1];
         int          n, len, nxt, k, v, p, w;
         n = distinct;
         for (int i = 0; i < n; i++) begin
            wt[i] = counts[arrival[i]];
            wl[i] = i;
         end
         for (int i = 1; i < n; i++) begin
            v = wl[i];
            k = i;
            while (k > 0 && wt[wl[k - 1]] < wt[v]) begin
               wl[k] = wl[k - 1];
               k--;
            end
            wl[k] = v;
         end
         len = n;
         nxt = n;
         while (len > 1) begin
            w = wt[wl[len - 1]] + wt[wl[len - 2]];
            wt[nxt] = w;
            lft[nxt] = wl[len - 1];
            rgt[nxt] = wl[len - 2];
            len -= 2;
            p = 0;
            while (p < len && wt[wl[p]] >= w) p++;
            for (k = len; k > p; k--) wl[k] = wl[k - 1];
            wl[p] = nxt;
            len++;
            nxt++;
         end
         nb[nxt - 1] = '0;
         nl[nxt - 1] = 0;
         for (k = nxt - 1; k >= n; k--) begin
            if (nl[k] < CODE_W) begin
               nb[lft[k]] = {nb[k][30:0], 1'b0};
               nb[rgt[k]] = {nb[k][30:0], 1'b1};
               nl[lft[k]] = nl[k] + 1;
               nl[rgt[k]] = nl[k] + 1;
            end else begin
               nb[lft[k]] = nb[k];
               nb[rgt[k]] = nb[k];
               nl[lft[k]] = nl[k];
               nl[rgt[k]] = nl[k];
            end
         end
         for (int i = 0; i < n; i++) begin
            tbl_bits[arrival[i]] = nb[i];
            tbl_len[arrival[i]] = nl[i];
         end
         built = 1;
      endfunction

      function void note(logic [2:0] func, logic [7:0] sym, logic [7:0] rank);
         answer_t a;
         int      r;
         a = '{STAT_OK, 8'd0, 32'd0, 6'd0, 9'd0};
         case (func)
            FUNC_APPEND: begin
               if (str_len >= MAX_LEN) begin
                  a.status = STAT_TOO_LONG;
               end else begin
                  if (counts[sym] == 0) begin
                     arrival[distinct] = sym;
                     distinct++;
                  end
                  counts[sym]++;
                  str_len++;
                  built = 0;
               end
            end
            FUNC_BUILD: begin
               if (distinct == 0) a.status = STAT_ABSENT;
               else build_tree();
            end
            FUNC_CODE: begin
               if (!built) begin
                  a.status = STAT_NO_CODE;
               end else if (counts[sym] == 0) begin
                  a.status = STAT_ABSENT;
               end else begin
                  a.symbol = sym;
                  a.bits = tbl_bits[sym];
                  a.length = tbl_len[sym];
               end
            end
            FUNC_RANK: begin
               if (!built) begin
                  a.status = STAT_NO_CODE;
               end else if (rank >= distinct) begin
                  a.status = STAT_ABSENT;
               end else begin
                  r = 0;
                  for (int s = 0; s < ALPHABET; s++) begin
                     if (counts[s] != 0) begin
                        if (r == rank) begin
                           a.symbol = s;
                           a.bits = tbl_bits[s];
                           a.length = tbl_len[s];
                           break;
                        end
                        r++;
                     end
                  end
               end
            end
            FUNC_CLEAR: begin
               foreach (counts[i]) counts[i] = 0;
               distinct = 0;
               str_len = 0;
               built = 0;
            end
            default: a.status = STAT_ABSENT;
         endcase
         a.distinct = distinct;
         answers.push_back(a);
      endfunction

      function void check(answer_t got);
         answer_t want;
         if (answers.size() == 0) begin
            $display("%0t: unexpected beat, status %0d symbol %0d", $realtime,
                     got.status, got.symbol);
            errors++;
            return;
         end
         want = answers.pop_front();
         if (got !== want) begin
            $display("%0t: expected status %0d symbol %0d bits %h len %0d distinct %0d",
                     $realtime, want.status, want.symbol, want.bits, want.length,
                     want.distinct);
            $display("%0t: actual   status %0d symbol %0d bits %h len %0d distinct %0d",
                     $realtime, got.status, got.symbol, got.bits, got.length,
                     got.distinct);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;
   logic [2:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [55:0] rsp_tdata;
   logic [1:0]  rsp_tuser;

   code_scoreboard sb = new();
   int idle_pct  = 0;
   int stall_pct = 0;
   int sent      = 0;

   huffman_code_builder_core uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #30_000_000;
      $display("tb: done, errors");
      $finish;
   end

   always @(posedge clock) begin
      answer_t got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.status = rsp_tuser;
         got.symbol = rsp_tdata[7:0];
         got.bits = rsp_tdata[39:8];
         got.length = rsp_tdata[45:40];
         got.distinct = rsp_tdata[54:46];
         sb.check(got);
      end
      if (reset) rsp_tready <= 1'b0;
      else rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   task automatic send(logic [2:0] func, logic [7:0] sym, logic [7:0] rank);
      if ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(4, 1)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= func;
      req_tdata <= {rank, sym};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note(func, sym, rank);
      sent++;
   endtask

   task automatic set_phase(int ph);
      case (ph % 5)
         1: begin idle_pct = 73; stall_pct = 0;  end
         2: begin idle_pct = 0;  stall_pct = 73; end
         3: begin idle_pct = 27; stall_pct = 27; end
         default: begin idle_pct = 0; stall_pct = 0; end
      endcase
   endtask

   task automatic run_queries(logic [7:0] pool[$], int count);
      for (int q = 0; q < count; q++) begin
         if ($urandom_range(1)) begin
            if (pool.size() > 0 && $urandom_range(3) != 0)
               send(FUNC_CODE, pool[$urandom_range(pool.size() - 1)], $urandom());
            else
               send(FUNC_CODE, $urandom(), $urandom());
         end else begin
            if ($urandom_range(3) != 0)
               send(FUNC_RANK, $urandom(), $urandom_range(sb.distinct));
            else
               send(FUNC_RANK, $urandom(), $urandom());
         end
      end
   endtask

   initial begin
      logic [7:0] pool[$];
      logic [7:0] perm[$];
      int         seq_no, k, t;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send(FUNC_CODE, 8'd0, 8'd0);
      send(FUNC_RANK, 8'd0, 8'd0);
      send(FUNC_BUILD, 8'd0, 8'd0);
      for (int f = FUNC_CLEAR + 1; f < 8; f++) send(f, 8'hFF, 8'hFF);
      send(FUNC_APPEND, 8'd0, 8'd0);
      send(FUNC_APPEND, 8'd255, 8'd0);
      send(FUNC_APPEND, 8'd255, 8'd0);
      send(FUNC_APPEND, 8'd128, 8'd0);
      send(FUNC_BUILD, 8'd0, 8'd0);
      send(FUNC_CODE, 8'd0, 8'd0);
      send(FUNC_CODE, 8'd255, 8'd0);
      send(FUNC_CODE, 8'd7, 8'd0);
      send(FUNC_RANK, 8'd0, 8'd0);
      send(FUNC_RANK, 8'd0, 8'd2);
      send(FUNC_RANK, 8'd0, 8'd3);
      send(FUNC_RANK, 8'd0, 8'd255);
      send(FUNC_APPEND, 8'd1, 8'd0);
      send(FUNC_CODE, 8'd0, 8'd0);
      send(FUNC_BUILD, 8'd0, 8'd0);
      send(FUNC_CODE, 8'd1, 8'd0);
      send(FUNC_CLEAR, 8'd0, 8'd0);
      send(FUNC_APPEND, 8'd42, 8'd0);
      send(FUNC_BUILD, 8'd0, 8'd0);
      send(FUNC_CODE, 8'd42, 8'd0);

      // One string over the whole alphabet that also overruns the length limit.
      send(FUNC_CLEAR, 8'd0, 8'd0);
      for (int s = 0; s < ALPHABET; s++) perm.push_back(s);
      perm.shuffle();
      foreach (perm[i]) send(FUNC_APPEND, perm[i], $urandom());
      while (sb.str_len < MAX_LEN) begin
         t = $urandom_range(255);
         send(FUNC_APPEND, ($urandom_range(1) ? t[7:0] : t[3:0]), $urandom());
      end
      repeat (6) send(FUNC_APPEND, $urandom(), $urandom());
      send(FUNC_BUILD, 8'd0, 8'd0);
      run_queries(perm, 30);
      send(FUNC_RANK, 8'd0, 8'd255);

      seq_no = 0;
      t = sent;
      while (sent - t < ITEMS) begin
         set_phase(seq_no / 3);
         seq_no++;
         if ($urandom_range(9) == 0) begin
            repeat ($urandom_range(4, 1))
               send($urandom_range(7), $urandom(), $urandom());
            continue;
         end
         if ($urandom_range(4) != 0) send(FUNC_CLEAR, $urandom(), $urandom());
         pool.delete();
         repeat ($urandom_range(($urandom_range(7) == 0) ? 40 : 8, 1))
            pool.push_back($urandom());
         k = $urandom_range(($urandom_range(7) == 0) ? 60 : 14, 1);
         for (int i = 0; i < k; i++)
            send(FUNC_APPEND, pool[$urandom_range(pool.size() - 1)], $urandom());
         if ($urandom_range(9) == 0) run_queries(pool, 2);
         send(FUNC_BUILD, $urandom(), $urandom());
         run_queries(pool, $urandom_range(10, 3));
      end
      set_phase(0);

      @(posedge clock);
      req_tvalid <= 1'b0;
      while (sb.answers.size() > 0) @(posedge clock);
      repeat (300) @(posedge clock);
      if (sb.errors == 0) $display("tb: done, clean");
      else $display("tb: done, errors");
      $finish;
   end

endmodule

// ----- huffman_code_builder_core.f -----
hw/rtl/hcb_pkg.sv
hw/rtl/hcb_ram.sv
hw/rtl/huffman_code_builder_core.sv
sim/tb.sv
